[rtl/spq_pkg.sv]
package spq_pkg;
  localparam int unsigned QueueDepth   = 32;
  localparam int unsigned PriorityBits = 8;
  localparam int unsigned AddrW        = $clog2(QueueDepth);
  localparam int unsigned CountW       = $clog2(QueueDepth + 1);

  localparam logic [2:0] ModeInsert   = 3'd0;
  localparam logic [2:0] ModePop      = 3'd1;
  localparam logic [2:0] ModeRemoveId = 3'd2;
  localparam logic [2:0] ModePeek     = 3'd3;
  localparam logic [2:0] ModeClear    = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StEmpty    = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef struct packed {
    logic [4:0]              id;
    logic [PriorityBits-1:0] prio;
  } entry_t;
endpackage

[rtl/spq_ram.sv]
module spq_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [spq_pkg::AddrW-1:0] waddr_i,
  input  spq_pkg::entry_t           wdata_i,
  input  logic [spq_pkg::AddrW-1:0] raddr_i,
  output spq_pkg::entry_t           rdata_o
);
  spq_pkg::entry_t mem [spq_pkg::QueueDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/stable_priority_process_queue.sv]
// clear, full insert, unused modes and pop, peek or remove-by-id on an empty queue go
// straight to the result strobe; peek and pop read the head slot, pop then shifts the rest up
// insert walks from the tail, moving each entry of lower priority behind the new one
// remove-by-id searches slot by slot for the id, then closes the gap slot by slot
// one request at a time: busy_o is high from acceptance through the result cycle
// reset: asynchronous, empties the queue; the receiver cannot stall, done_o marks each result
module stable_priority_process_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [2:0]                         mode_i,
  input  logic [4:0]                         entry_id_i,
  input  logic [7:0]                         priority_req_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [4:0]                         out_id_o,
  output logic [7:0]                         out_priority_o,
  output logic                               is_empty_o,
  output logic [5:0]                         occupancy_o
);
  localparam int unsigned AW = spq_pkg::AddrW;
  localparam int unsigned CW = spq_pkg::CountW;
  localparam int unsigned PB = spq_pkg::PriorityBits;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1; // wait for read data
  localparam logic [2:0] SIns  = 3'd2; // shift down from tail
  localparam logic [2:0] SFind = 3'd3; // search for id
  localparam logic [2:0] SDel  = 3'd4; // shift up over gap
  localparam logic [2:0] SDone = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [2:0]    mode_q;
  logic [4:0]    id_q;
  logic [PB-1:0] pr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [1:0]    st_q, st_d;
  spq_pkg::entry_t res_q, res_d;
  logic          done_q, done_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  spq_pkg::entry_t wdata, rdata;
  logic [CW-1:0]   idx_m1, idx_p1;
  logic            accept;

  spq_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign accept = start_i && !busy_o;
  assign idx_m1 = idx_q - CW'(1);
  assign idx_p1 = idx_q + CW'(1);

  // insert walks from the tail: read slot idx-1, if its priority is below the
  // new one move it to idx, else place new entry at idx
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    st_d    = st_q;
    res_d   = res_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = idx_q[AW-1:0];
    wdata   = rdata;
    raddr   = idx_q[AW-1:0];
    case (state_q)
      SIdle: begin
        if (accept) begin
          st_d  = spq_pkg::StOk;
          res_d = '0;
          idx_d = '0;
          state_d = SDone;
          case (mode_i)
            spq_pkg::ModeInsert: begin
              if (cnt_q >= CW'(spq_pkg::QueueDepth)) st_d = spq_pkg::StFull;
              else begin
                idx_d = cnt_q;
                state_d = SIns;
                raddr = idx_m1[AW-1:0];
                if (cnt_q == '0) raddr = '0;
                if (cnt_q != '0) begin
                  raddr = cnt_q[AW-1:0] - AW'(1);
                  state_d = SRead;
                end
              end
            end
            spq_pkg::ModePop, spq_pkg::ModePeek, spq_pkg::ModeRemoveId: begin
              raddr = '0;
              if (cnt_q == '0)
                st_d = (mode_i == spq_pkg::ModeRemoveId) ? spq_pkg::StNotFound
                                                         : spq_pkg::StEmpty;
              else state_d = SRead;
            end
            spq_pkg::ModeClear: cnt_d = '0;
            default: ;
          endcase
        end
      end
      SRead: begin
        case (mode_q)
          spq_pkg::ModeInsert: begin
            state_d = SIns;
            raddr = idx_m1[AW-1:0];
          end
          default: state_d = SFind;
        endcase
      end
      SIns: begin
        // rdata is slot idx-1 when idx > 0
        we = 1'b1;
        if (idx_q != '0 && rdata.prio < pr_q) begin
          wdata = rdata;
          idx_d = idx_m1;
          raddr = (idx_m1 == '0) ? '0 : AW'(idx_m1 - CW'(1));
          if (idx_m1 != '0) state_d = SRead;
        end else begin
          wdata.id = id_q;
          wdata.prio = pr_q;
          cnt_d = cnt_q + CW'(1);
          state_d = SDone;
        end
      end
      SFind: begin
        // rdata is slot idx
        if (mode_q == spq_pkg::ModeRemoveId && rdata.id != id_q) begin
          if (idx_p1 >= cnt_q) begin
            st_d = spq_pkg::StNotFound;
            state_d = SDone;
          end else begin
            idx_d = idx_p1;
            raddr = idx_p1[AW-1:0];
            state_d = SRead;
          end
        end else begin
          res_d = rdata;
          if (mode_q == spq_pkg::ModePeek) state_d = SDone;
          else if (idx_p1 >= cnt_q) begin
            cnt_d = cnt_q - CW'(1);
            state_d = SDone;
          end else begin
            raddr = idx_p1[AW-1:0];
            state_d = SDel;
          end
        end
      end
      SDel: begin
        // rdata is slot idx+1, move it to idx
        we = 1'b1;
        wdata = rdata;
        idx_d = idx_p1;
        if (idx_p1 + CW'(1) >= cnt_q) begin
          cnt_d = cnt_q - CW'(1);
          state_d = SDone;
        end else raddr = AW'(idx_p1 + CW'(1));
      end
      SDone: begin
        done_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    st_q  <= st_d;
    res_q <= res_d;
    if (state_q == SIdle && accept) begin
      mode_q <= mode_i;
      id_q   <= entry_id_i;
      pr_q   <= PB'(priority_req_i);
    end
  end

  assign busy_o         = (state_q != SIdle) || done_q;
  assign done_o         = done_q;
  assign status_o       = st_q;
  assign out_id_o       = res_q.id;
  assign out_priority_o = 8'(res_q.prio);
  assign is_empty_o     = (cnt_q == '0);
  assign occupancy_o    = 6'(cnt_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(spq_pkg::QueueDepth))
    else $error("occupancy beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("double result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != spq_pkg::StOk) |-> (out_id_o == '0 && out_priority_o == '0))
    else $error("payload on failed request");
endmodule
